// ===== design/dfs_maze_explorer_step_top_assert.svh =====
// Assertion helpers for the maze explorer top level.
`ifndef DFS_MAZE_EXPLORER_STEP_TOP_ASSERT_SVH
`define DFS_MAZE_EXPLORER_STEP_TOP_ASSERT_SVH

// same-cycle implication
`define DFSME_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DFSME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/dfsme_pkg.sv =====
package dfsme_pkg;

  localparam int GRID_SIDE   = 16;
  localparam int STACK_DEPTH = 256;

  localparam int COORD_W   = 4;
  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int FA_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
  localparam int FRAME_W   = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXIT_X = 2'd0,
    CFG_EXIT_Y = 2'd1,
    CFG_ENTR_X = 2'd2,
    CFG_ENTR_Y = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic               wall_left;
    logic               wall_right;
    logic               wall_up;
    logic               wall_down;
  } in_item_t;

  typedef struct packed {
    logic [1:0] next_dir;
    logic       retreating;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RD_UP,
    ST_RD_DN,
    ST_PUSH,
    ST_POP,
    ST_POP_FIX,
    ST_CHOOSE
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic rd_up;
    logic rd_dn;
    logic push;
    logic pop;
    logic pop_fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic entrance_hit;
    logic advancing;
    logic depth_zero;
    logic depth_ge2;
    logic out_free;
  } status_t;

endpackage

// ===== design/dfsme_ram.sv =====
module dfsme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dfsme_ctrl.sv =====
module dfsme_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dfsme_pkg::status_t status_i,
  output dfsme_pkg::cmd_t    cmd_o
);

  dfsme_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfsme_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dfsme_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dfsme_pkg::ST_PREP;
      end
      dfsme_pkg::ST_PREP: begin
        if (status_i.entrance_hit || status_i.advancing) begin
          state_d = dfsme_pkg::ST_RD_UP;
        end else begin
          state_d = dfsme_pkg::ST_POP;
        end
      end
      dfsme_pkg::ST_RD_UP:   state_d = dfsme_pkg::ST_RD_DN;
      dfsme_pkg::ST_RD_DN:   state_d = dfsme_pkg::ST_PUSH;
      dfsme_pkg::ST_PUSH:    state_d = dfsme_pkg::ST_CHOOSE;
      dfsme_pkg::ST_POP: begin
        if (status_i.depth_ge2) begin
          state_d = dfsme_pkg::ST_POP_FIX;
        end else begin
          state_d = dfsme_pkg::ST_CHOOSE;
        end
      end
      dfsme_pkg::ST_POP_FIX: state_d = dfsme_pkg::ST_CHOOSE;
      dfsme_pkg::ST_CHOOSE: begin
        if (status_i.out_free) state_d = dfsme_pkg::ST_IDLE;
      end
      default:               state_d = dfsme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      dfsme_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      dfsme_pkg::ST_PREP:    cmd_o.prep    = 1'b1;
      dfsme_pkg::ST_RD_UP:   cmd_o.rd_up   = 1'b1;
      dfsme_pkg::ST_RD_DN:   cmd_o.rd_dn   = 1'b1;
      dfsme_pkg::ST_PUSH:    cmd_o.push    = 1'b1;
      dfsme_pkg::ST_POP:     cmd_o.pop     = 1'b1;
      dfsme_pkg::ST_POP_FIX: cmd_o.pop_fix = 1'b1;
      dfsme_pkg::ST_CHOOSE:  cmd_o.commit  = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/dfsme_dp.sv =====
module dfsme_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dfsme_pkg::in_item_t                 in_item_i,
  output dfsme_pkg::out_item_t                out_item_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic                                cfg_valid_i,
  input  logic [dfsme_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dfsme_pkg::COORD_W-1:0]       cfg_data_i,
  input  dfsme_pkg::cmd_t                     cmd_i,
  output dfsme_pkg::status_t                  status_o,
  // visited row memory
  output logic                                vis_we_o,
  output logic [dfsme_pkg::IDX_W-1:0]         vis_waddr_o,
  output logic [dfsme_pkg::GRID_SIDE-1:0]     vis_wdata_o,
  output logic [dfsme_pkg::IDX_W-1:0]         vis_raddr_o,
  input  logic [dfsme_pkg::GRID_SIDE-1:0]     vis_rdata_i,
  // frame stack memory
  output logic                                frm_we_o,
  output logic [dfsme_pkg::FA_W-1:0]          frm_waddr_o,
  output logic [dfsme_pkg::FRAME_W-1:0]       frm_wdata_o,
  output logic [dfsme_pkg::FA_W-1:0]          frm_raddr_o,
  input  logic [dfsme_pkg::FRAME_W-1:0]       frm_rdata_i
);

  logic [dfsme_pkg::COORD_W-1:0] exit_x_q, exit_y_q, entr_x_q, entr_y_q;

  dfsme_pkg::in_item_t                item_q;
  logic [dfsme_pkg::DEPTH_W-1:0]      depth_q, depth_d;
  logic [dfsme_pkg::FRAME_W-1:0]      top_q, top_d;
  logic                               adv_q, adv_d;
  logic [1:0]                         arr_q, arr_d;
  logic [dfsme_pkg::GRID_SIDE-1:0]    row_valid_q, row_valid_d;
  logic [dfsme_pkg::IDX_W-1:0]        rd_row_q;
  logic [dfsme_pkg::GRID_SIDE-1:0]    row_y_q, row_up_q;
  logic                               out_valid_q;
  dfsme_pkg::out_item_t               out_item_q;

  logic [dfsme_pkg::GRID_SIDE-1:0]    row_now;
  logic [dfsme_pkg::COORD_W-1:0]      cx, cy;
  logic                               x_in, y_in;
  logic [3:0]                         walls, nb_ok, nb_vis, open_new;
  logic [1:0]                         back_dir;
  logic [dfsme_pkg::FRAME_W-1:0]      new_frame, fixed_frame, top_eff;
  logic [dfsme_pkg::FA_W-1:0]         push_addr;
  logic [dfsme_pkg::IDX_W-1:0]        xi, xl, xr, yi, yu, yd;
  logic [3:0]                         open;
  logic [1:0]                         come, pick, dir;
  logic [2:0]                         cnt;
  logic                               retreat;
  logic                               hit;

  assign cx = item_q.cur_x;
  assign cy = item_q.cur_y;

  assign xi = dfsme_pkg::IDX_W'(32'(cx));
  assign xl = dfsme_pkg::IDX_W'(32'(cx) - 32'd1);
  assign xr = dfsme_pkg::IDX_W'(32'(cx) + 32'd1);
  assign yi = dfsme_pkg::IDX_W'(32'(cy));
  assign yu = dfsme_pkg::IDX_W'(32'(cy) - 32'd1);
  assign yd = dfsme_pkg::IDX_W'(32'(cy) + 32'd1);

  assign x_in = 32'(cx) < 32'(dfsme_pkg::GRID_SIDE);
  assign y_in = 32'(cy) < 32'(dfsme_pkg::GRID_SIDE);

  assign hit = (cx == entr_x_q) && (cy == entr_y_q);

  // rows never written since the last restart read as all clear
  assign row_now = row_valid_q[rd_row_q] ? vis_rdata_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_x_q <= dfsme_pkg::COORD_W'(15);
      exit_y_q <= dfsme_pkg::COORD_W'(15);
      entr_x_q <= '0;
      entr_y_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dfsme_pkg::CFG_EXIT_X: exit_x_q <= cfg_data_i;
        dfsme_pkg::CFG_EXIT_Y: exit_y_q <= cfg_data_i;
        dfsme_pkg::CFG_ENTR_X: entr_x_q <= cfg_data_i;
        dfsme_pkg::CFG_ENTR_Y: entr_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame of a forward move
  always_comb begin
    walls = {item_q.wall_down, item_q.wall_up, item_q.wall_right, item_q.wall_left};
    nb_ok[dfsme_pkg::DIR_LEFT]  = (cx != '0) && y_in &&
                                  (32'(cx) - 32'd1 < 32'(dfsme_pkg::GRID_SIDE));
    nb_ok[dfsme_pkg::DIR_RIGHT] = y_in && (32'(cx) + 32'd1 < 32'(dfsme_pkg::GRID_SIDE));
    nb_ok[dfsme_pkg::DIR_UP]    = (cy != '0) && x_in &&
                                  (32'(cy) - 32'd1 < 32'(dfsme_pkg::GRID_SIDE));
    nb_ok[dfsme_pkg::DIR_DOWN]  = x_in && (32'(cy) + 32'd1 < 32'(dfsme_pkg::GRID_SIDE));
    nb_vis[dfsme_pkg::DIR_LEFT]  = nb_ok[dfsme_pkg::DIR_LEFT]  && row_y_q[xl];
    nb_vis[dfsme_pkg::DIR_RIGHT] = nb_ok[dfsme_pkg::DIR_RIGHT] && row_y_q[xr];
    nb_vis[dfsme_pkg::DIR_UP]    = nb_ok[dfsme_pkg::DIR_UP]    && row_up_q[xi];
    nb_vis[dfsme_pkg::DIR_DOWN]  = nb_ok[dfsme_pkg::DIR_DOWN]  && row_now[xi];
    back_dir  = arr_q ^ 2'b01;
    open_new  = ~walls & nb_ok & ~nb_vis & ~(4'b0001 << back_dir);
    new_frame = {arr_q, open_new};
  end

  assign fixed_frame = {frm_rdata_i[5:4], frm_rdata_i[3:0] & ~(4'b0001 << top_q[5:4])};

  assign push_addr = (depth_q < dfsme_pkg::DEPTH_W'(dfsme_pkg::STACK_DEPTH)) ?
                     dfsme_pkg::FA_W'(depth_q) :
                     dfsme_pkg::FA_W'(dfsme_pkg::STACK_DEPTH - 1);

  // move choice
  always_comb begin
    top_eff = (depth_q == '0) ? '0 : top_q;
    open    = top_eff[3:0];
    come    = top_eff[5:4];
    cnt     = 3'(open[0]) + 3'(open[1]) + 3'(open[2]) + 3'(open[3]);
    if (open[dfsme_pkg::DIR_UP]) begin
      pick = dfsme_pkg::DIR_UP;
    end else if (open[dfsme_pkg::DIR_DOWN]) begin
      pick = dfsme_pkg::DIR_DOWN;
    end else if (open[dfsme_pkg::DIR_LEFT]) begin
      pick = dfsme_pkg::DIR_LEFT;
    end else begin
      pick = dfsme_pkg::DIR_RIGHT;
    end
    retreat = 1'b0;
    if (cx > exit_x_q && open[dfsme_pkg::DIR_LEFT]) begin
      dir = dfsme_pkg::DIR_LEFT;
    end else if (cx < exit_x_q && open[dfsme_pkg::DIR_RIGHT]) begin
      dir = dfsme_pkg::DIR_RIGHT;
    end else if (cy > exit_y_q && open[dfsme_pkg::DIR_UP]) begin
      dir = dfsme_pkg::DIR_UP;
    end else if (cy < exit_y_q && open[dfsme_pkg::DIR_DOWN]) begin
      dir = dfsme_pkg::DIR_DOWN;
    end else if (cnt >= 3'd2) begin
      dir = open[come] ? come : pick;
    end else if (cnt == 3'd1) begin
      dir = pick;
    end else begin
      dir     = come ^ 2'b01;
      retreat = 1'b1;
    end
  end

  always_comb begin
    depth_d     = depth_q;
    top_d       = top_q;
    adv_d       = adv_q;
    arr_d       = arr_q;
    row_valid_d = row_valid_q;
    if (cmd_i.prep && hit) begin
      depth_d     = '0;
      adv_d       = 1'b1;
      arr_d       = dfsme_pkg::DIR_LEFT;
      row_valid_d = '0;
    end
    if (cmd_i.push) begin
      top_d = new_frame;
      if (depth_q < dfsme_pkg::DEPTH_W'(dfsme_pkg::STACK_DEPTH)) begin
        depth_d = depth_q + dfsme_pkg::DEPTH_W'(1);
      end
    end
    if (cmd_i.pop && (depth_q != '0)) begin
      depth_d = depth_q - dfsme_pkg::DEPTH_W'(1);
    end
    if (cmd_i.pop_fix) begin
      top_d = fixed_frame;
    end
    if (cmd_i.commit) begin
      adv_d = !retreat;
      if (!retreat) arr_d = dir;
      if (x_in && y_in) row_valid_d[yi] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      adv_q       <= 1'b1;
      arr_q       <= dfsme_pkg::DIR_LEFT;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      adv_q       <= adv_d;
      arr_q       <= arr_d;
      row_valid_q <= row_valid_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.prep || cmd_i.rd_up || cmd_i.rd_dn) rd_row_q <= vis_raddr_o;
    if (cmd_i.rd_up || cmd_i.pop) row_y_q <= row_now;
    if (cmd_i.rd_dn) row_up_q <= row_now;
    if (cmd_i.commit) begin
      out_item_q.next_dir   <= dir;
      out_item_q.retreating <= retreat;
    end
  end

  always_comb begin
    if (cmd_i.rd_up) begin
      vis_raddr_o = yu;
    end else if (cmd_i.rd_dn) begin
      vis_raddr_o = yd;
    end else begin
      vis_raddr_o = yi;
    end
    vis_we_o    = cmd_i.commit && x_in && y_in;
    vis_waddr_o = yi;
    vis_wdata_o = row_y_q;
    if (retreat) begin
      vis_wdata_o[xi] = 1'b0;
    end else if (adv_q) begin
      vis_wdata_o[xi] = 1'b1;
    end
  end

  assign frm_raddr_o = dfsme_pkg::FA_W'(depth_q - dfsme_pkg::DEPTH_W'(2));
  assign frm_we_o    = cmd_i.push || cmd_i.pop_fix;
  assign frm_waddr_o = cmd_i.push ? push_addr :
                       dfsme_pkg::FA_W'(depth_q - dfsme_pkg::DEPTH_W'(1));
  assign frm_wdata_o = cmd_i.push ? new_frame : fixed_frame;

  assign status_o.entrance_hit = hit;
  assign status_o.advancing    = adv_q;
  assign status_o.depth_zero   = (depth_q == '0);
  assign status_o.depth_ge2    = (depth_q >= dfsme_pkg::DEPTH_W'(2));
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/dfs_maze_explorer_step_top.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o  | in_item_i (cell, four walls)
// out     | output    | out_valid_o / out_stall_i| out_item_o (next_dir, retreating)
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Forward move per item: three visited-row reads, then frame push, then choice.
// Backtrack: pop, read-modify-write of the new top frame when one remains, then choice.
// The step sequence is set by the single read port of the visited-row and frame RAMs.
// Reset needs no clearing pass; row valid bits stand in for the visited map clear.
// A stalled result holds in the output register; the next transfer waits only in
// the choice state until that register frees up.
`include "dfs_maze_explorer_step_top_assert.svh"

module dfs_maze_explorer_step_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dfsme_pkg::in_item_t             in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dfsme_pkg::out_item_t            out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dfsme_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dfsme_pkg::COORD_W-1:0]   cfg_data_i
);

  dfsme_pkg::cmd_t    cmd;
  dfsme_pkg::status_t status;

  logic                              vis_we;
  logic [dfsme_pkg::IDX_W-1:0]       vis_waddr, vis_raddr;
  logic [dfsme_pkg::GRID_SIDE-1:0]   vis_wdata, vis_rdata;
  logic                              frm_we;
  logic [dfsme_pkg::FA_W-1:0]        frm_waddr, frm_raddr;
  logic [dfsme_pkg::FRAME_W-1:0]     frm_wdata, frm_rdata;

  assign cfg_ready_o = 1'b1;

  dfsme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfsme_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .vis_we_o    (vis_we),
    .vis_waddr_o (vis_waddr),
    .vis_wdata_o (vis_wdata),
    .vis_raddr_o (vis_raddr),
    .vis_rdata_i (vis_rdata),
    .frm_we_o    (frm_we),
    .frm_waddr_o (frm_waddr),
    .frm_wdata_o (frm_wdata),
    .frm_raddr_o (frm_raddr),
    .frm_rdata_i (frm_rdata)
  );

  dfsme_ram #(
    .WIDTH (dfsme_pkg::GRID_SIDE),
    .DEPTH (dfsme_pkg::GRID_SIDE)
  ) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  dfsme_ram #(
    .WIDTH (dfsme_pkg::FRAME_W),
    .DEPTH (dfsme_pkg::STACK_DEPTH)
  ) u_frm_ram (
    .clk_i   (clk_i),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (frm_wdata),
    .raddr_i (frm_raddr),
    .rdata_o (frm_rdata)
  );

  `DFSME_ASSERT_NEXT(a_accept_then_busy, in_valid_i && !in_stall_o, in_stall_o)
  `DFSME_ASSERT_NEXT(a_commit_loads_out, cmd.commit, out_valid_o)
  `DFSME_ASSERT_NEXT(a_push_not_empty, cmd.push, !status.depth_zero)
  `DFSME_ASSERT_IMPL(a_single_cmd, 1'b1, $onehot0(cmd))

endmodule
